// ----- design/mfd_pkg.sv -----
// Shared types and constants for the motor feedback frame decoder.
// No dependencies; imported by motor_feedback_frame_decoder and tb_top.
`default_nettype none

package mfd_pkg;

    localparam int ID_W     = 11;
    localparam int BYTE_W   = 8;
    localparam int ANGLE_W  = 16;
    localparam int TURN_W   = 32;
    localparam int SPEED_W  = 16;
    localparam int CUR_W    = 16;
    localparam int MOTOR_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int REG_COUNT = 4;

    // Half a revolution at 8192 counts per revolution
    localparam logic signed [ANGLE_W:0] HALF_TURN = (ANGLE_W+1)'(4096);
    localparam logic signed [TURN_W-1:0] TURN_MAX = {1'b0, {(TURN_W-1){1'b1}}};
    localparam logic signed [TURN_W-1:0] TURN_MIN = {1'b1, {(TURN_W-1){1'b0}}};

    localparam logic [ID_W-1:0] ID_LEFT_RST     = ID_W'(513);
    localparam logic [ID_W-1:0] ID_RIGHT_RST    = ID_W'(514);
    localparam logic [ID_W-1:0] ID_CENTER_RST   = ID_W'(515);
    localparam logic [ID_W-1:0] ID_RELOADER_RST = ID_W'(517);

    typedef enum logic [MOTOR_W-1:0] {
        MOTOR_LEFT     = 2'd0,
        MOTOR_RIGHT    = 2'd1,
        MOTOR_CENTER   = 2'd2,
        MOTOR_RELOADER = 2'd3
    } motor_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ID_LEFT     = 2'd0,
        REG_ID_RIGHT    = 2'd1,
        REG_ID_CENTER   = 2'd2,
        REG_ID_RELOADER = 2'd3
    } cfg_reg_t;

endpackage

`default_nettype wire

// ----- design/motor_feedback_frame_decoder.sv -----
// Motor feedback frame decoder: ID match, field unpack, multi-turn tracking.
// Depends on mfd_pkg for widths, register indexes and motor codes.
`default_nettype none

// Pipeline: frame register, then result register. Throughput: one frame
//   per cycle unless the result channel stalls; the per-motor angle and turn
//   state is read and rewritten in the single compare stage.
// Frames matching no configured ID leave no result and no state change.
// Reset: ID registers return to 513/514/515/517, per-motor last angle and
//   turn count clear to zero, both pipeline stages empty.
module motor_feedback_frame_decoder
    import mfd_pkg::*;
#(
    parameter int MOTOR_COUNT = 4
) (
    input  wire  logic                       clk,
    input  wire  logic                       rst_n,
    // configuration write port
    input  wire  logic                       cfg_wen,
    input  wire  logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire  logic [ID_W-1:0]            cfg_wdata,
    // frame input channel
    input  wire  logic                       in_valid,
    output logic                             in_stall,
    input  wire  logic [ID_W-1:0]            frame_id,
    input  wire  logic [BYTE_W-1:0]          byte0,
    input  wire  logic [BYTE_W-1:0]          byte1,
    input  wire  logic [BYTE_W-1:0]          byte2,
    input  wire  logic [BYTE_W-1:0]          byte3,
    input  wire  logic [BYTE_W-1:0]          byte4,
    input  wire  logic [BYTE_W-1:0]          byte5,
    input  wire  logic [BYTE_W-1:0]          byte6,
    input  wire  logic [BYTE_W-1:0]          byte7,
    // result channel
    output logic                             out_valid,
    input  wire  logic                       out_stall,
    output logic [MOTOR_W-1:0]               motor,
    output logic [ANGLE_W-1:0]               angle_raw,
    output logic signed [TURN_W-1:0]         turns,
    output logic signed [SPEED_W-1:0]        speed_rpm,
    output logic signed [CUR_W-1:0]          current_raw,
    output logic [BYTE_W-1:0]                temperature
);

    // Only the first MOTOR_COUNT of the four configured IDs can ever match
    localparam int SLOT_COUNT = (MOTOR_COUNT < REG_COUNT) ? MOTOR_COUNT : REG_COUNT;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [ID_W-1:0] id_reg [REG_COUNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_reg[REG_ID_LEFT]     <= ID_LEFT_RST;
            id_reg[REG_ID_RIGHT]    <= ID_RIGHT_RST;
            id_reg[REG_ID_CENTER]   <= ID_CENTER_RST;
            id_reg[REG_ID_RELOADER] <= ID_RELOADER_RST;
        end
        else if (cfg_wen)
        begin
            id_reg[cfg_index] <= cfg_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: frame register
    // ------------------------------------------------------------------
    logic               s1_valid_reg;
    logic [ID_W-1:0]    s1_id_reg;
    logic [ANGLE_W-1:0] s1_angle_reg;
    logic [SPEED_W-1:0] s1_speed_reg;
    logic [CUR_W-1:0]   s1_cur_reg;
    logic [BYTE_W-1:0]  s1_temp_reg;

    logic in_xfer;
    logic s1_hit;
    logic s1_move;
    logic out_load;
    logic out_free;

    assign in_xfer = in_valid && !in_stall;

    // Result register can take a new value when empty or being drained
    assign out_free = !out_valid || !out_stall;
    // A non-matching frame just drops out of stage 1
    assign s1_move  = s1_valid_reg && (!s1_hit || out_free);
    assign out_load = s1_valid_reg && s1_hit && out_free;
    // Hold the input only while stage 1 is occupied and cannot advance
    assign in_stall = s1_valid_reg && !s1_move;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // byte7 carries nothing the decoder uses
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_id_reg    <= frame_id;
            s1_angle_reg <= {byte0, byte1};
            s1_speed_reg <= {byte2, byte3};
            s1_cur_reg   <= {byte4, byte5};
            s1_temp_reg  <= byte6;
        end
    end

    logic unused_byte7;
    assign unused_byte7 = ^byte7;

    // ------------------------------------------------------------------
    // ID match: lowest motor index wins
    // ------------------------------------------------------------------
    logic [MOTOR_W-1:0] s1_sel;

    always_comb
    begin
        s1_hit = 1'b0;
        s1_sel = MOTOR_LEFT;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (id_reg[i] == s1_id_reg)
            begin
                s1_hit = 1'b1;
                s1_sel = MOTOR_W'(i);
            end
        end
    end

    // ------------------------------------------------------------------
    // Per-motor state and turn tracking
    // ------------------------------------------------------------------
    logic [ANGLE_W-1:0]       last_angle_reg [SLOT_COUNT];
    logic signed [TURN_W-1:0] turn_count_reg [SLOT_COUNT];

    logic [ANGLE_W-1:0]       cur_last;
    logic signed [TURN_W-1:0] cur_turns;
    logic signed [ANGLE_W:0]  delta;
    logic signed [TURN_W-1:0] turns_next;

    always_comb
    begin
        cur_last  = '0;
        cur_turns = '0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (s1_sel == MOTOR_W'(i))
            begin
                cur_last  = last_angle_reg[i];
                cur_turns = turn_count_reg[i];
            end
        end
    end

    // Difference over the full 16-bit range, one sign bit wider
    assign delta = $signed({1'b0, s1_angle_reg}) - $signed({1'b0, cur_last});

    always_comb
    begin
        turns_next = cur_turns;
        if (delta > HALF_TURN)
        begin
            if (cur_turns != TURN_MIN)
            begin
                turns_next = cur_turns - TURN_W'(1);
            end
        end
        else if (delta < -HALF_TURN)
        begin
            if (cur_turns != TURN_MAX)
            begin
                turns_next = cur_turns + TURN_W'(1);
            end
        end
    end

    for (genvar g = 0; g < SLOT_COUNT; g++)
    begin : g_slot
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                last_angle_reg[g] <= '0;
                turn_count_reg[g] <= '0;
            end
            else if (out_load && s1_sel == MOTOR_W'(g))
            begin
                last_angle_reg[g] <= s1_angle_reg;
                turn_count_reg[g] <= turns_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid <= out_load;
        end
    end

    // Temperature is reported for the left and right motors only
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            motor       <= s1_sel;
            angle_raw   <= s1_angle_reg;
            turns       <= turns_next;
            speed_rpm   <= s1_speed_reg;
            current_raw <= s1_cur_reg;
            temperature <= (s1_sel == MOTOR_LEFT || s1_sel == MOTOR_RIGHT) ?
                           s1_temp_reg : '0;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && s1_hit)
        else $error("input stalled without a pending matched frame");

    a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(s1_valid_reg) && $past(s1_hit))
        else $error("result appeared without a matched frame");

    a_motor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid && (int'(motor) < SLOT_COUNT))
        else $error("result motor index outside configured slots");

    a_turn_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (turns_next == cur_turns) ||
                     (turns_next == cur_turns + TURN_W'(1)) ||
                     (turns_next == cur_turns - TURN_W'(1)))
        else $error("turn count moved by more than one");

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking testbench for motor_feedback_frame_decoder: identifier matching,
// big-endian field unpacking and per-motor multi-turn tracking, checked by a local predictor.
// Depends on mfd_pkg and the motor_feedback_frame_decoder RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mfd_pkg::*;

    localparam int MOTOR_COUNT   = 4;
    localparam int HALF_REV      = 4096;    // half a revolution in encoder counts
    localparam int CYCLE_LIMIT   = 200000;  // far above the slowest correct run
    localparam int DRAIN_CYCLES  = 2000;
    localparam int SETTLE_CYCLES = 6;       // two-stage pipeline plus margin
    localparam int MAX_REPORTS   = 10;
    localparam int IDLE_PERCENT  = 15;

    // One received frame; data[0] is payload byte 0
    typedef struct packed {
        logic [ID_W-1:0]             id;
        logic [7:0][BYTE_W-1:0]      data;
    } frame_t;

    // One decoded feedback record, laid out like the result ports
    typedef struct packed {
        motor_t                      motor;
        logic [ANGLE_W-1:0]          angle;
        logic signed [TURN_W-1:0]    turns;
        logic signed [SPEED_W-1:0]   speed;
        logic signed [CUR_W-1:0]     current;
        logic [BYTE_W-1:0]           temp;
    } feedback_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_wen = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [ID_W-1:0]            cfg_wdata = '0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic [ID_W-1:0]            frame_id = '0;
    logic [BYTE_W-1:0]          byte0 = '0;
    logic [BYTE_W-1:0]          byte1 = '0;
    logic [BYTE_W-1:0]          byte2 = '0;
    logic [BYTE_W-1:0]          byte3 = '0;
    logic [BYTE_W-1:0]          byte4 = '0;
    logic [BYTE_W-1:0]          byte5 = '0;
    logic [BYTE_W-1:0]          byte6 = '0;
    logic [BYTE_W-1:0]          byte7 = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [MOTOR_W-1:0]         motor;
    logic [ANGLE_W-1:0]         angle_raw;
    logic signed [TURN_W-1:0]   turns;
    logic signed [SPEED_W-1:0]  speed_rpm;
    logic signed [CUR_W-1:0]    current_raw;
    logic [BYTE_W-1:0]          temperature;

    // Predictor state: the identifier table and per-motor tracking state
    logic [ID_W-1:0]            motor_id [MOTOR_COUNT];
    logic [ANGLE_W-1:0]         prev_angle [MOTOR_COUNT];
    logic signed [TURN_W-1:0]   turn_ctr [MOTOR_COUNT];

    feedback_t                  pending_fb [$];   // decoded records not yet seen at the output
    int                         fail_count = 0;
    int                         cycle_count = 0;
    bit                         idle_on = 1'b1;   // random gaps and stalls enabled

    motor_feedback_frame_decoder #(
        .MOTOR_COUNT(MOTOR_COUNT)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wen(cfg_wen),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .frame_id(frame_id),
        .byte0(byte0),
        .byte1(byte1),
        .byte2(byte2),
        .byte3(byte3),
        .byte4(byte4),
        .byte5(byte5),
        .byte6(byte6),
        .byte7(byte7),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .motor(motor),
        .angle_raw(angle_raw),
        .turns(turns),
        .speed_rpm(speed_rpm),
        .current_raw(current_raw),
        .temperature(temperature)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Watchdog: a hung handshake or a lost result ends the run here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[motor_feedback_frame_decoder] ERROR");
            $finish;
        end
    end

    function automatic void note_failure(input string msg);
        if (fail_count < MAX_REPORTS)
            $display("%s", msg);
        fail_count++;
    endfunction

    // Lowest motor index wins when several registers hold the same identifier;
    // indexes at or above MOTOR_COUNT never match.
    function automatic int lookup_motor(input logic [ID_W-1:0] id);
        for (int i = 0; i < MOTOR_COUNT; i++)
        begin
            if (motor_id[i] == id)
                return i;
        end
        return -1;
    endfunction

    // Decode one frame and advance the tracking state of the matched motor.
    // Returns 0 for a frame that matches no motor; then nothing changes.
    function automatic bit decode_frame(input frame_t f, output feedback_t fb);
        int                 m;
        int                 delta;
        logic [ANGLE_W-1:0] ang;

        fb = '0;
        m = lookup_motor(f.id);
        if (m < 0)
            return 1'b0;

        ang = {f.data[0], f.data[1]};
        // Difference over the full 16-bit range, angles above 8191 included
        delta = int'(ang) - int'(prev_angle[m]);
        if (delta > HALF_REV)
        begin
            if (turn_ctr[m] != TURN_MIN)
                turn_ctr[m] = turn_ctr[m] - 1;
        end
        else if (delta < -HALF_REV)
        begin
            if (turn_ctr[m] != TURN_MAX)
                turn_ctr[m] = turn_ctr[m] + 1;
        end
        prev_angle[m] = ang;

        fb.motor   = motor_t'(m);
        fb.angle   = ang;
        fb.turns   = turn_ctr[m];
        fb.speed   = {f.data[2], f.data[3]};
        fb.current = {f.data[4], f.data[5]};
        // Only the left and right motors report a temperature
        fb.temp    = (fb.motor == MOTOR_LEFT || fb.motor == MOTOR_RIGHT) ? f.data[6] : '0;
        return 1'b1;
    endfunction

    function automatic frame_t make_frame(input logic [ID_W-1:0] id,
                                          input logic [15:0] ang, spd, cur,
                                          input logic [7:0] tmp, spare);
        frame_t f;
        f.id      = id;
        f.data[0] = ang[15:8];
        f.data[1] = ang[7:0];
        f.data[2] = spd[15:8];
        f.data[3] = spd[7:0];
        f.data[4] = cur[15:8];
        f.data[5] = cur[7:0];
        f.data[6] = tmp;
        f.data[7] = spare;
        return f;
    endfunction

    // Offer one frame, hold it until the transfer, then record its expected result.
    // Valid stays high on return so back-to-back frames need no second assignment.
    task automatic send_frame(input frame_t f, output bit hit);
        feedback_t fb;

        if (idle_on)
        begin
            while ($urandom_range(99) < IDLE_PERCENT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        frame_id <= f.id;
        byte0    <= f.data[0];
        byte1    <= f.data[1];
        byte2    <= f.data[2];
        byte3    <= f.data[3];
        byte4    <= f.data[4];
        byte5    <= f.data[5];
        byte6    <= f.data[6];
        byte7    <= f.data[7];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        hit = decode_frame(f, fb);
        if (hit)
            pending_fb.push_back(fb);
    endtask

    task automatic send(input frame_t f);
        bit hit;
        send_frame(f, hit);
    endtask

    // Drop valid, wait for every expected record, then let unmatched frames
    // still in the pipeline drain before any register write.
    task automatic drain();
        int waited = 0;

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_fb.size() != 0 && waited < DRAIN_CYCLES)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_fb.size() != 0)
        begin
            note_failure($sformatf("%0d expected results never arrived", pending_fb.size()));
            fail_count += pending_fb.size() - 1;
            pending_fb.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all four identifier registers on consecutive cycles
    task automatic write_ids(input logic [ID_W-1:0] id_l, id_r, id_c, id_rl);
        logic [ID_W-1:0] ids [REG_COUNT];

        ids = '{id_l, id_r, id_c, id_rl};
        for (int i = 0; i < REG_COUNT; i++)
        begin
            cfg_wen   <= 1'b1;
            cfg_index <= cfg_reg_t'(i);
            cfg_wdata <= ids[i];
            @(posedge clk);
            motor_id[i] = ids[i];
        end
        cfg_wen <= 1'b0;
    endtask

    // Pick a new angle relative to the last one so that half-turn crossings,
    // the exact half-turn boundary and wraps of the 16-bit field all come up.
    function automatic logic [15:0] pick_angle(input logic [15:0] last);
        logic [15:0] step;

        case ($urandom_range(4))
            0: return last + 16'($urandom_range(200)) - 16'd100;
            1:
            begin
                step = 16'($urandom_range(4098, 4094));
                return $urandom_range(1) ? last + step : last - step;
            end
            2: return 16'($urandom_range(8191));
            3: return 16'($urandom);
            default: return (last >= 16'(HALF_REV)) ? 16'($urandom_range(90))
                                                    : 16'($urandom_range(8191, 8100));
        endcase
    endfunction

    // Reset identifiers, every motor, counter steps both ways, the exact
    // half-turn boundary, angles above 8191, unmatched frames, field extremes.
    task automatic test_reset_ids();
        send(make_frame(ID_LEFT_RST, 16'h0000, 16'h7FFF, 16'h8000, 8'hFF, 8'h00));
        send(make_frame(ID_LEFT_RST, 16'd8191, 16'h8000, 16'h7FFF, 8'h00, 8'hFF));
        send(make_frame(ID_LEFT_RST, 16'd0, 16'h0000, 16'h0000, 8'h5A, 8'hA5));
        send(make_frame(ID_RIGHT_RST, 16'd4096, 16'hFFFF, 16'h0001, 8'h81, 8'h7E));
        send(make_frame(ID_RIGHT_RST, 16'd0, 16'h0001, 16'hFFFF, 8'h3C, 8'hC3));
        send(make_frame(ID_RIGHT_RST, 16'd8191, 16'h1234, 16'hEDCB, 8'h42, 8'h24));
        send(make_frame(ID_RIGHT_RST, 16'd4095, 16'h8001, 16'h7FFE, 8'h7F, 8'h80));
        // center and reloader report no temperature
        send(make_frame(ID_CENTER_RST, 16'd4097, 16'h00FF, 16'hFF00, 8'hAB, 8'h01));
        send(make_frame(ID_RELOADER_RST, 16'hFFFF, 16'hFF00, 16'h00FF, 8'hCD, 8'h02));
        send(make_frame(ID_RELOADER_RST, 16'h0000, 16'h5555, 16'hAAAA, 8'hEF, 8'h04));
        send(make_frame(ID_RELOADER_RST, 16'h8000, 16'hAAAA, 16'h5555, 8'h10, 8'h08));
        // identifiers that match nothing
        send(make_frame(11'd516, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF));
        send(make_frame(11'd0, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00));
        send(make_frame(11'd2047, 16'h1FFF, 16'h7FFF, 16'h8000, 8'h20, 8'h40));
        send(make_frame(ID_LEFT_RST, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF));
        send(make_frame(ID_CENTER_RST, 16'd0, 16'h7FFF, 16'h7FFF, 8'hFF, 8'h00));
        drain();
    endtask

    // Shared identifiers resolve to the lowest motor index
    task automatic test_shared_ids();
        write_ids(11'd0, 11'd0, 11'd0, 11'd0);
        send(make_frame(11'd0, 16'd100, 16'h0102, 16'h0304, 8'h11, 8'h22));
        send(make_frame(11'd1, 16'd200, 16'h0506, 16'h0708, 8'h33, 8'h44));
        drain();
        write_ids(11'd2047, 11'd5, 11'd5, 11'd5);
        send(make_frame(11'd5, 16'd6000, 16'h1111, 16'h2222, 8'h55, 8'h66));
        send(make_frame(11'd2047, 16'd9000, 16'h3333, 16'h4444, 8'h77, 8'h88));
        drain();
        write_ids(11'd1, 11'd2, 11'd2047, 11'd2047);
        send(make_frame(11'd2047, 16'd7000, 16'h9999, 16'h6666, 8'h99, 8'hAA));
        send(make_frame(11'd2, 16'd1, 16'h0000, 16'hFFFF, 8'hBB, 8'hCC));
        drain();
        write_ids(11'd1, 11'd2, 11'd3, 11'd2047);
        send(make_frame(11'd2047, 16'd7001, 16'hFFFF, 16'h0000, 8'hDD, 8'hEE));
        send(make_frame(11'd3, 16'd12000, 16'h7FFF, 16'h8000, 8'hF0, 8'h0F));
        drain();
    endtask

    // One identifier setting with random traffic: most frames target a
    // configured motor, the rest carry a random identifier.
    task automatic run_traffic(input logic [ID_W-1:0] id_l, id_r, id_c, id_rl,
                               input int want_hits, input bit quiet);
        int          hits = 0;
        int          m;
        bit          hit;
        logic [ID_W-1:0] id;
        logic [15:0] ang;

        write_ids(id_l, id_r, id_c, id_rl);
        idle_on = !quiet;
        while (hits < want_hits)
        begin
            if ($urandom_range(99) < 85)
                id = motor_id[$urandom_range(MOTOR_COUNT - 1)];
            else
                id = ID_W'($urandom_range(2047));
            m = lookup_motor(id);
            ang = (m >= 0) ? pick_angle(prev_angle[m]) : 16'($urandom);
            send_frame(make_frame(id, ang, 16'($urandom), 16'($urandom),
                                  8'($urandom), 8'($urandom)), hit);
            if (hit)
                hits++;
        end
        drain();
        idle_on = 1'b1;
    endtask

    // Several identifier settings: extremes, wide random, crowded (duplicates likely),
    // and back to the reset values. The second runs without any gaps or stalls.
    task automatic test_random_traffic();
        run_traffic(11'd0, 11'd2047, 11'd1024, 11'd1, 250, 1'b0);
        run_traffic(ID_W'($urandom_range(2047)), ID_W'($urandom_range(2047)),
                    ID_W'($urandom_range(2047)), ID_W'($urandom_range(2047)), 250, 1'b1);
        run_traffic(ID_W'($urandom_range(3)), ID_W'($urandom_range(3)),
                    ID_W'($urandom_range(3)), ID_W'($urandom_range(3)), 250, 1'b0);
        run_traffic(ID_LEFT_RST, ID_RIGHT_RST, ID_CENTER_RST, ID_RELOADER_RST, 250, 1'b0);
    endtask

    // Result side: random stall, then compare each transfer with the oldest record
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= idle_on && ($urandom_range(99) < IDLE_PERCENT);
    end

    always @(posedge clk)
    begin : check_results
        feedback_t got;
        feedback_t want;

        if (rst_n && out_valid && !out_stall)
        begin
            got.motor   = motor_t'(motor);
            got.angle   = angle_raw;
            got.turns   = turns;
            got.speed   = speed_rpm;
            got.current = current_raw;
            got.temp    = temperature;
            if (pending_fb.size() == 0)
            begin
                note_failure($sformatf("unexpected result: motor %0d angle %0d turns %0d",
                                       got.motor, got.angle, got.turns));
            end
            else
            begin
                want = pending_fb.pop_front();
                if (got.motor !== want.motor || got.angle !== want.angle ||
                    got.turns !== want.turns || got.speed !== want.speed ||
                    got.current !== want.current || got.temp !== want.temp)
                begin
                    note_failure($sformatf(
                        "mismatch: expected motor %0d angle %0d turns %0d speed %0d cur %0d temp %0d; got motor %0d angle %0d turns %0d speed %0d cur %0d temp %0d",
                        want.motor, want.angle, want.turns, want.speed, want.current, want.temp,
                        got.motor, got.angle, got.turns, got.speed, got.current, got.temp));
                end
            end
        end
    end

    initial
    begin
        // Predictor starts from the reset state of the block
        motor_id[0] = ID_LEFT_RST;
        motor_id[1] = ID_RIGHT_RST;
        motor_id[2] = ID_CENTER_RST;
        motor_id[3] = ID_RELOADER_RST;
        for (int i = 0; i < MOTOR_COUNT; i++)
        begin
            prev_angle[i] = '0;
            turn_ctr[i]   = '0;
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The turn counter limits lie about 2^31 frames away and are not reached here
        test_reset_ids();
        test_shared_ids();
        test_random_traffic();

        if (fail_count == 0)
            $display("[motor_feedback_frame_decoder] OK");
        else
            $display("[motor_feedback_frame_decoder] ERROR");
        $finish;
    end

endmodule
